FILE: rtl/sdft_pkg.sv
`default_nettype none

package sdft_pkg;

  localparam int SEGMENTS  = 10;
  localparam int NUM_VERTS = 3 * SEGMENTS;
  localparam int K_W       = $clog2(NUM_VERTS);
  localparam int SEG_W     = $clog2(SEGMENTS);
  localparam int SEGC_W    = $clog2(SEGMENTS + 1);

  localparam logic [15:0] SCALE_RESET = 16'd4096;

  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 31;
  localparam int FIFO_DEPTH = 2;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned Q30_HALF    = 64'd536870912;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [31:0] cen_x;
    logic signed [31:0] cen_y;
    logic signed [31:0] cen_z;
    logic signed [15:0] nrm_x;
    logic signed [15:0] nrm_y;
    logic signed [15:0] nrm_z;
    logic [35:0]        radius;
    logic signed [31:0] p0;
    logic signed [31:0] p2;
    logic signed [32:0] q0;
    logic signed [32:0] q1;
    logic signed [32:0] q2;
    logic               degen;
  } disk_t;

  typedef logic [SEGMENTS-1:0][63:0] trig_tab_t;

  function automatic longint unsigned mulq30(longint unsigned a, longint unsigned b);
    return (a * b + Q30_HALF) >> 30;
  endfunction

  function automatic trig_tab_t build_trig();
    trig_tab_t tab;
    longint unsigned ph, f, x, x2, ts, tc, sv, cv;
    longint c0, s0, c, s;
    logic swap;
    longint unsigned quad;
    tab = '0;
    for (int i = 0; i < SEGMENTS; i++) begin
      ph   = (((longint'(i)) << 32) + SEGMENTS / 2) / SEGMENTS;
      ph   = ph & 64'hFFFF_FFFF;
      quad = (ph >> 30) & 64'd3;
      f    = ph & (Q30_ONE - 64'd1);
      swap = (f > Q30_HALF);
      if (swap) begin
        f = Q30_ONE - f;
      end
      x  = (f * HALF_PI_Q30 + Q30_HALF) >> 30;
      x2 = mulq30(x, x);
      ts = Q30_ONE;
      ts = Q30_ONE - mulq30(x2, ts) / 72;
      ts = Q30_ONE - mulq30(x2, ts) / 42;
      ts = Q30_ONE - mulq30(x2, ts) / 20;
      ts = Q30_ONE - mulq30(x2, ts) / 6;
      sv = mulq30(x, ts);
      tc = Q30_ONE;
      tc = Q30_ONE - mulq30(x2, tc) / 90;
      tc = Q30_ONE - mulq30(x2, tc) / 56;
      tc = Q30_ONE - mulq30(x2, tc) / 30;
      tc = Q30_ONE - mulq30(x2, tc) / 12;
      tc = Q30_ONE - mulq30(x2, tc) / 2;
      cv = tc;
      c0 = swap ? longint'(sv) : longint'(cv);
      s0 = swap ? longint'(cv) : longint'(sv);
      case (quad)
        64'd0: begin c = c0;  s = s0;  end
        64'd1: begin c = -s0; s = c0;  end
        64'd2: begin c = -c0; s = -s0; end
        default: begin c = s0; s = -c0; end
      endcase
      tab[i] = {c[31:0], s[31:0]};
    end
    return tab;
  endfunction

  localparam trig_tab_t TRIG_TAB = build_trig();

endpackage

`default_nettype wire

FILE: rtl/sdft_front.sv
`default_nettype none

module sdft_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [15:0]        scale_i,
  input  logic signed [31:0] cen_x_i,
  input  logic signed [31:0] cen_y_i,
  input  logic signed [31:0] cen_z_i,
  input  logic [31:0]        radius_i,
  input  logic signed [15:0] nrm_x_i,
  input  logic signed [15:0] nrm_y_i,
  input  logic signed [15:0] nrm_z_i,
  input  logic               full_i,
  output logic               push_o,
  output sdft_pkg::disk_t    entry_o
);

  localparam int SQ_W  = 61;
  localparam int RW    = 60;
  localparam int QW    = 31;
  localparam int DIV_N = 5;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQRT = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_PUSH = 5'b10000
  } fstate_e;

  fstate_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  sdft_pkg::disk_t ent_q, ent_d;
  logic [SQ_W-1:0] xl_q, xl_d, xm_q, xm_d, rl_q, rl_d, rm_q, rm_d, bit_q, bit_d;
  logic [SQ_W-1:0] dsl_q, dsl_d, dsm_q, dsm_d;
  logic [RW-1:0] rem_q [DIV_N];
  logic [RW-1:0] rem_d [DIV_N];
  logic [QW-1:0] quo_q [DIV_N];
  logic [QW-1:0] quo_d [DIV_N];
  logic [DIV_N-1:0] neg_q, neg_d;
  logic signed [63:0] prod_q [4];
  logic signed [63:0] prod_d [4];

  logic signed [31:0] nxx, nyy, nzz;
  logic [31:0] s2, t2;
  logic [47:0] rprod;
  logic [2*SQ_W-1:0] stl, stm;
  logic signed [31:0] sval [DIV_N];
  logic signed [32:0] q0, q1, q2;

  function automatic logic [2*SQ_W-1:0] sqrt_step(logic [SQ_W-1:0] x, logic [SQ_W-1:0] res,
                                                 logic [SQ_W-1:0] b);
    logic [SQ_W-1:0] trial;
    trial = res + b;
    if (x >= trial) begin
      return {x - trial, (res >> 1) + b};
    end
    return {x, res >> 1};
  endfunction

  function automatic logic [15:0] mag16(logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic signed [32:0] rr30(logic signed [63:0] v);
    logic [63:0] m;
    logic [32:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = 33'((m + 64'(sdft_pkg::Q30_HALF)) >> 30);
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  assign nxx   = 32'(nrm_x_i) * 32'(nrm_x_i);
  assign nyy   = 32'(nrm_y_i) * 32'(nrm_y_i);
  assign nzz   = 32'(nrm_z_i) * 32'(nrm_z_i);
  assign s2    = nxx + nzz;
  assign t2    = s2 + nyy;
  assign rprod = {16'd0, radius_i} * {32'd0, scale_i};
  assign stl   = sqrt_step(xl_q, rl_q, bit_q);
  assign stm   = sqrt_step(xm_q, rm_q, bit_q);

  always_comb begin
    for (int i = 0; i < DIV_N; i++) begin
      sval[i] = neg_q[i] ? -$signed({1'b0, quo_q[i]}) : $signed({1'b0, quo_q[i]});
    end
  end

  assign q0 = rr30(prod_q[0]);
  assign q1 = rr30(prod_q[1]) - rr30(prod_q[2]);
  assign q2 = -rr30(prod_q[3]);

  always_comb begin
    entry_o = ent_q;
    if (ent_q.degen) begin
      entry_o.p0 = '0;
      entry_o.p2 = '0;
      entry_o.q0 = '0;
      entry_o.q1 = '0;
      entry_o.q2 = '0;
    end else begin
      entry_o.p0 = sval[0];
      entry_o.p2 = sval[1];
      entry_o.q0 = q0;
      entry_o.q1 = q1;
      entry_o.q2 = q2;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign push_o = (state_q == ST_PUSH) && !full_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ent_d   = ent_q;
    xl_d    = xl_q;
    xm_d    = xm_q;
    rl_d    = rl_q;
    rm_d    = rm_q;
    bit_d   = bit_q;
    dsl_d   = dsl_q;
    dsm_d   = dsm_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    neg_d   = neg_q;
    prod_d  = prod_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ent_d        = '0;
          ent_d.cen_x  = cen_x_i;
          ent_d.cen_y  = cen_y_i;
          ent_d.cen_z  = cen_z_i;
          ent_d.nrm_x  = nrm_x_i;
          ent_d.nrm_y  = nrm_y_i;
          ent_d.nrm_z  = nrm_z_i;
          ent_d.radius = 36'((rprod + 48'd2048) >> 12);
          ent_d.degen  = (nrm_x_i == 16'sd0) && (nrm_z_i == 16'sd0);
          xl_d         = {1'b0, s2, 28'd0};
          xm_d         = {1'b0, t2, 28'd0};
          rl_d         = '0;
          rm_d         = '0;
          bit_d        = {1'b1, {(SQ_W-1){1'b0}}};
          cnt_d        = '0;
          state_d      = ST_SQRT;
        end
      end
      ST_SQRT: begin
        xl_d  = stl[2*SQ_W-1:SQ_W];
        rl_d  = stl[SQ_W-1:0];
        xm_d  = stm[2*SQ_W-1:SQ_W];
        rm_d  = stm[SQ_W-1:0];
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(sdft_pkg::SQRT_STEPS - 1)) begin
          cnt_d    = '0;
          state_d  = ST_DIV;
          dsl_d    = {stl[30:0], 30'd0};
          dsm_d    = {stm[30:0], 30'd0};
          rem_d[0] = {mag16(ent_q.nrm_z), 44'd0};
          rem_d[1] = {mag16(ent_q.nrm_x), 44'd0};
          rem_d[2] = {mag16(ent_q.nrm_x), 44'd0};
          rem_d[3] = {mag16(ent_q.nrm_y), 44'd0};
          rem_d[4] = {mag16(ent_q.nrm_z), 44'd0};
          neg_d[0] = ent_q.nrm_z[15];
          neg_d[1] = !ent_q.nrm_x[15] && (ent_q.nrm_x != 16'sd0);
          neg_d[2] = ent_q.nrm_x[15];
          neg_d[3] = ent_q.nrm_y[15];
          neg_d[4] = ent_q.nrm_z[15];
          for (int i = 0; i < DIV_N; i++) begin
            quo_d[i] = '0;
          end
        end
      end
      ST_DIV: begin
        for (int i = 0; i < DIV_N; i++) begin
          if ({1'b0, rem_q[i]} >= ((i < 2) ? dsl_q : dsm_q)) begin
            rem_d[i] = rem_q[i] - ((i < 2) ? dsl_q[RW-1:0] : dsm_q[RW-1:0]);
            quo_d[i] = {quo_q[i][QW-2:0], 1'b1};
          end else begin
            quo_d[i] = {quo_q[i][QW-2:0], 1'b0};
          end
        end
        dsl_d = dsl_q >> 1;
        dsm_d = dsm_q >> 1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(sdft_pkg::DIV_STEPS - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d[0] = 64'(sval[3]) * 64'(sval[1]);
        prod_d[1] = 64'(sval[4]) * 64'(sval[0]);
        prod_d[2] = 64'(sval[2]) * 64'(sval[1]);
        prod_d[3] = 64'(sval[3]) * 64'(sval[0]);
        state_d   = ST_PUSH;
      end
      ST_PUSH: begin
        if (!full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    xl_q   <= xl_d;
    xm_q   <= xm_d;
    rl_q   <= rl_d;
    rm_q   <= rm_d;
    bit_q  <= bit_d;
    dsl_q  <= dsl_d;
    dsm_q  <= dsm_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
  end

endmodule

`default_nettype wire

FILE: rtl/sdft_fifo.sv
`default_nettype none

module sdft_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sdft_pkg::disk_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output sdft_pkg::disk_t data_o,
  output logic            empty_o
);

  localparam int PTR_W = $clog2(sdft_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(sdft_pkg::FIFO_DEPTH + 1);

  sdft_pkg::disk_t mem_q [sdft_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(sdft_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == PTR_W'(sdft_pkg::FIFO_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
    end
    if (do_pop) begin
      rp_d = (rp_q == PTR_W'(sdft_pkg::FIFO_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sdft_back.sv
`default_nettype none

module sdft_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  sdft_pkg::disk_t    head_i,
  output logic               pop_o,
  output logic               vertex_valid_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [15:0] out_normal_x_o,
  output logic signed [15:0] out_normal_y_o,
  output logic signed [15:0] out_normal_z_o,
  output logic [4:0]         vertex_number_o,
  output logic               last_vertex_o,
  output logic               degenerate_o
);

  localparam int KW = sdft_pkg::K_W;

  logic act_q, act_d;
  logic [KW-1:0] k_q, k_d;
  logic [1:0] sub_q, sub_d;
  logic [sdft_pkg::SEGC_W-1:0] seg_q, seg_d, seg_eff;
  sdft_pkg::disk_t cur_q, cur_d;
  logic done_disk, is_centre;

  logic a_v_q, b_v_q, c_v_q, d_v_q, e_v_q, f_v_q;
  logic [KW-1:0] a_k_q, b_k_q, c_k_q, d_k_q, e_k_q;
  logic a_ctr_q, b_ctr_q, c_ctr_q, d_ctr_q;
  sdft_pkg::disk_t a_disk_q, b_disk_q, c_disk_q, d_disk_q, e_disk_q;
  logic [63:0] a_cs_q;

  logic signed [31:0] a_c, a_s;
  logic signed [31:0] pv [3];
  logic signed [32:0] qv [3];
  logic signed [63:0] b_cp_q [3];
  logic signed [64:0] b_sq_q [3];
  logic [27:0] c_mag_q [3];
  logic [27:0] c_mag_d [3];
  logic [2:0]  c_neg_q, c_neg_d, d_neg_q;
  logic [63:0] d_prod_q [3];
  logic signed [38:0] e_off_q [3];
  logic signed [38:0] e_off_d [3];
  logic signed [31:0] pos_d [3];
  logic signed [31:0] cen [3];

  assign done_disk = act_q && (k_q == KW'(sdft_pkg::NUM_VERTS - 1));
  assign pop_o     = (!act_q || done_disk) && !empty_i;
  assign is_centre = (k_q != '0) && (k_q != KW'(sdft_pkg::NUM_VERTS - 1)) && (sub_q == 2'd0);
  assign seg_eff   = ((k_q == '0) || (k_q == KW'(sdft_pkg::NUM_VERTS - 1)) || is_centre)
                     ? '0 : seg_q;

  always_comb begin
    act_d = act_q;
    k_d   = k_q;
    sub_d = sub_q;
    seg_d = seg_q;
    cur_d = cur_q;
    if (pop_o) begin
      act_d = 1'b1;
      k_d   = '0;
      sub_d = 2'd0;
      seg_d = sdft_pkg::SEGC_W'(1);
      cur_d = head_i;
    end else if (done_disk) begin
      act_d = 1'b0;
    end else if (act_q) begin
      k_d = k_q + KW'(1);
      if (k_q != '0) begin
        if (sub_q == 2'd2) begin
          sub_d = 2'd0;
          seg_d = seg_q + sdft_pkg::SEGC_W'(1);
        end else begin
          sub_d = sub_q + 2'd1;
        end
      end
    end
  end

  assign a_c   = a_cs_q[63:32];
  assign a_s   = a_cs_q[31:0];
  assign pv[0] = a_disk_q.p0;
  assign pv[1] = '0;
  assign pv[2] = a_disk_q.p2;
  assign qv[0] = a_disk_q.q0;
  assign qv[1] = a_disk_q.q1;
  assign qv[2] = a_disk_q.q2;
  assign cen[0] = e_disk_q.cen_x;
  assign cen[1] = e_disk_q.cen_y;
  assign cen[2] = e_disk_q.cen_z;

  always_comb begin
    logic signed [65:0] sum;
    logic [65:0] m;
    logic [37:0] om;
    logic signed [39:0] tot;
    for (int a = 0; a < 3; a++) begin
      sum = 66'(b_cp_q[a]) + 66'(b_sq_q[a]);
      m   = sum[65] ? 66'(-sum) : 66'(sum);
      c_mag_d[a] = 28'((m + 66'd8589934592) >> 34);
      c_neg_d[a] = sum[65];
      om = 38'((d_prod_q[a] + 64'd33554432) >> 26);
      if (d_ctr_q) begin
        e_off_d[a] = '0;
      end else if (d_neg_q[a]) begin
        e_off_d[a] = -$signed({1'b0, om});
      end else begin
        e_off_d[a] = $signed({1'b0, om});
      end
      tot = 40'(cen[a]) + 40'(e_off_q[a]);
      if (tot[39:31] != {9{tot[39]}}) begin
        pos_d[a] = tot[39] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        pos_d[a] = tot[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
    end else begin
      act_q <= act_d;
      a_v_q <= act_q;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    sub_q    <= sub_d;
    seg_q    <= seg_d;
    cur_q    <= cur_d;
    a_k_q    <= k_q;
    a_ctr_q  <= is_centre || cur_q.degen;
    a_cs_q   <= sdft_pkg::TRIG_TAB[seg_eff[sdft_pkg::SEG_W-1:0]];
    a_disk_q <= cur_q;
    b_k_q    <= a_k_q;
    b_ctr_q  <= a_ctr_q;
    b_disk_q <= a_disk_q;
    for (int a = 0; a < 3; a++) begin
      b_cp_q[a]   <= 64'(a_c) * 64'(pv[a]);
      b_sq_q[a]   <= 65'(a_s) * 65'(qv[a]);
      c_mag_q[a]  <= c_mag_d[a];
      d_prod_q[a] <= {28'd0, c_disk_q.radius} * {36'd0, c_mag_q[a]};
      e_off_q[a]  <= e_off_d[a];
    end
    c_k_q    <= b_k_q;
    c_ctr_q  <= b_ctr_q;
    c_disk_q <= b_disk_q;
    c_neg_q  <= c_neg_d;
    d_k_q    <= c_k_q;
    d_ctr_q  <= c_ctr_q;
    d_disk_q <= c_disk_q;
    d_neg_q  <= c_neg_q;
    e_k_q    <= d_k_q;
    e_disk_q <= d_disk_q;
    pos_x_o         <= pos_d[0];
    pos_y_o         <= pos_d[1];
    pos_z_o         <= pos_d[2];
    out_normal_x_o  <= e_disk_q.nrm_x;
    out_normal_y_o  <= e_disk_q.nrm_y;
    out_normal_z_o  <= e_disk_q.nrm_z;
    vertex_number_o <= 5'(e_k_q);
    last_vertex_o   <= (e_k_q == KW'(sdft_pkg::NUM_VERTS - 1));
    degenerate_o    <= e_disk_q.degen;
  end

  assign vertex_valid_o = f_v_q;

endmodule

`default_nettype wire

FILE: rtl/splat_disk_fan_tessellator_unit.sv
// The front takes each request through a 31-step bit-serial square root and then
// a 31-step restoring divider, followed by the cross product and the queue push.
// The back then emits the 30 fan vertices back to back. The receiver cannot stall;
// a new request is taken only once the front has pushed the previous one into the
// queue. Reset is asynchronous and active low; it empties the queue and sets the
// scale to 1.0.
`default_nettype none

module splat_disk_fan_tessellator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [31:0]        disk_radius_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  output logic               vertex_valid_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [15:0] out_normal_x_o,
  output logic signed [15:0] out_normal_y_o,
  output logic signed [15:0] out_normal_z_o,
  output logic [4:0]         vertex_number_o,
  output logic               last_vertex_o,
  output logic               degenerate_o
);

  logic [15:0] scale_q;
  logic push, full, pop, empty;
  sdft_pkg::disk_t push_data, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= sdft_pkg::SCALE_RESET;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  sdft_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .scale_i  (scale_q),
    .cen_x_i  (center_x_i),
    .cen_y_i  (center_y_i),
    .cen_z_i  (center_z_i),
    .radius_i (disk_radius_i),
    .nrm_x_i  (normal_x_i),
    .nrm_y_i  (normal_y_i),
    .nrm_z_i  (normal_z_i),
    .full_i   (full),
    .push_o   (push),
    .entry_o  (push_data)
  );

  sdft_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head),
    .empty_o (empty)
  );

  sdft_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head),
    .pop_o           (pop),
    .vertex_valid_o  (vertex_valid_o),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .pos_z_o         (pos_z_o),
    .out_normal_x_o  (out_normal_x_o),
    .out_normal_y_o  (out_normal_y_o),
    .out_normal_z_o  (out_normal_z_o),
    .vertex_number_o (vertex_number_o),
    .last_vertex_o   (last_vertex_o),
    .degenerate_o    (degenerate_o)
  );

endmodule

`default_nettype wire

FILE: rtl/sdft_chk.sv
`default_nettype none

module sdft_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [15:0]        cfg_wdata_i,
  input logic               start_i,
  input logic               busy_o,
  input logic signed [31:0] center_x_i,
  input logic signed [31:0] center_y_i,
  input logic signed [31:0] center_z_i,
  input logic [31:0]        disk_radius_i,
  input logic signed [15:0] normal_x_i,
  input logic signed [15:0] normal_y_i,
  input logic signed [15:0] normal_z_i,
  input logic               vertex_valid_o,
  input logic signed [31:0] pos_x_o,
  input logic signed [31:0] pos_y_o,
  input logic signed [31:0] pos_z_o,
  input logic signed [15:0] out_normal_x_o,
  input logic signed [15:0] out_normal_y_o,
  input logic signed [15:0] out_normal_z_o,
  input logic [4:0]         vertex_number_o,
  input logic               last_vertex_o,
  input logic               degenerate_o
);

  a_fan_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vertex_valid_o && !last_vertex_o |=>
      vertex_valid_o && (vertex_number_o == $past(vertex_number_o) + 5'd1))
    else $error("fan vertices not contiguous");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vertex_valid_o && last_vertex_o |-> vertex_number_o == 5'(sdft_pkg::NUM_VERTS - 1))
    else $error("last vertex at wrong index");

  a_disk_attrs_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vertex_valid_o && !last_vertex_o |=>
      $stable(out_normal_x_o) && $stable(out_normal_y_o) && $stable(out_normal_z_o)
      && $stable(degenerate_o))
    else $error("disk attributes changed inside a fan");

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("front not busy after a request");

endmodule

bind splat_disk_fan_tessellator_unit sdft_chk u_sdft_chk (.*);

`default_nettype wire

FILE: bench/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 90;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic [4:0]  num;
    logic        last;
    logic        degen;
  } vertex_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [15:0]        cfg_wdata_i = '0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [31:0] center_x_i = '0;
  logic signed [31:0] center_y_i = '0;
  logic signed [31:0] center_z_i = '0;
  logic [31:0]        disk_radius_i = '0;
  logic signed [15:0] normal_x_i = '0;
  logic signed [15:0] normal_y_i = '0;
  logic signed [15:0] normal_z_i = '0;
  logic               vertex_valid_o;
  logic signed [31:0] pos_x_o;
  logic signed [31:0] pos_y_o;
  logic signed [31:0] pos_z_o;
  logic signed [15:0] out_normal_x_o;
  logic signed [15:0] out_normal_y_o;
  logic signed [15:0] out_normal_z_o;
  logic [4:0]         vertex_number_o;
  logic               last_vertex_o;
  logic               degenerate_o;

  vertex_t     fan_q[$];
  logic [15:0] radius_scale = sdft_pkg::SCALE_RESET;
  int          mismatches = 0;
  int          cycles = 0;
  int          idle_pct = 0;

  splat_disk_fan_tessellator_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .start_i(start_i), .busy_o(busy_o),
    .center_x_i(center_x_i), .center_y_i(center_y_i), .center_z_i(center_z_i),
    .disk_radius_i(disk_radius_i),
    .normal_x_i(normal_x_i), .normal_y_i(normal_y_i), .normal_z_i(normal_z_i),
    .vertex_valid_o(vertex_valid_o),
    .pos_x_o(pos_x_o), .pos_y_o(pos_y_o), .pos_z_o(pos_z_o),
    .out_normal_x_o(out_normal_x_o), .out_normal_y_o(out_normal_y_o),
    .out_normal_z_o(out_normal_z_o),
    .vertex_number_o(vertex_number_o), .last_vertex_o(last_vertex_o),
    .degenerate_o(degenerate_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint div_toward_zero(longint num, longint unsigned den);
    longint unsigned mag;
    mag = (num < 0) ? longint'(-num) : num;
    mag = mag / den;
    return (num < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint round_away(longint x, int k);
    longint unsigned half, mag;
    half = 64'd1 << (k - 1);
    mag = (x < 0) ? longint'(-x) : x;
    mag = (mag + half) >> k;
    return (x < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic void rim_angle(int seg, output longint c, output longint s);
    longint unsigned ph, f, x, x2, ts, tc, sv, cv;
    longint c0, s0;
    logic [1:0] quad;
    logic swap;
    ph = ((longint'(seg) << 32) + sdft_pkg::SEGMENTS / 2) / sdft_pkg::SEGMENTS;
    ph = ph & 64'hFFFF_FFFF;
    quad = ph[31:30];
    f = ph & ((64'd1 << 30) - 1);
    swap = f > (64'd1 << 29);
    if (swap) f = (64'd1 << 30) - f;
    x = (f * 64'd1686629713 + (64'd1 << 29)) >> 30;
    x2 = q30_mul(x, x);
    ts = 64'd1 << 30;
    ts = (64'd1 << 30) - q30_mul(x2, ts) / 72;
    ts = (64'd1 << 30) - q30_mul(x2, ts) / 42;
    ts = (64'd1 << 30) - q30_mul(x2, ts) / 20;
    ts = (64'd1 << 30) - q30_mul(x2, ts) / 6;
    sv = q30_mul(x, ts);
    tc = 64'd1 << 30;
    tc = (64'd1 << 30) - q30_mul(x2, tc) / 90;
    tc = (64'd1 << 30) - q30_mul(x2, tc) / 56;
    tc = (64'd1 << 30) - q30_mul(x2, tc) / 30;
    tc = (64'd1 << 30) - q30_mul(x2, tc) / 12;
    tc = (64'd1 << 30) - q30_mul(x2, tc) / 2;
    cv = tc;
    c0 = swap ? longint'(sv) : longint'(cv);
    s0 = swap ? longint'(cv) : longint'(sv);
    case (quad)
      2'd0: begin c = c0; s = s0; end
      2'd1: begin c = -s0; s = c0; end
      2'd2: begin c = -c0; s = -s0; end
      default: begin c = s0; s = -c0; end
    endcase
  endfunction

  function automatic void predict_fan(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                      logic [31:0] rad, logic [15:0] nx, logic [15:0] ny,
                                      logic [15:0] nz);
    longint cen[3], n[3], p[3], q[3], u[3], c, s, w, off, v;
    longint unsigned r, s2, t2, len_xz, len_all, mag;
    logic degen, centre;
    int seg, j;
    vertex_t vx;
    cen[0] = longint'(signed'(cx));
    cen[1] = longint'(signed'(cy));
    cen[2] = longint'(signed'(cz));
    n[0] = longint'(signed'(nx));
    n[1] = longint'(signed'(ny));
    n[2] = longint'(signed'(nz));
    p = '{0, 0, 0};
    q = '{0, 0, 0};
    r = (longint'(rad) * longint'(radius_scale) + 2048) >> 12;
    degen = (n[0] == 0) && (n[2] == 0);
    if (!degen) begin
      s2 = n[0] * n[0] + n[2] * n[2];
      t2 = s2 + n[1] * n[1];
      len_xz = floor_sqrt(s2 << 28);
      len_all = floor_sqrt(t2 << 28);
      p[0] = div_toward_zero(n[2] * (longint'(1) << 44), len_xz);
      p[2] = div_toward_zero(-n[0] * (longint'(1) << 44), len_xz);
      for (int a = 0; a < 3; a++) u[a] = div_toward_zero(n[a] * (longint'(1) << 44), len_all);
      q[0] = round_away(u[1] * p[2], 30);
      q[1] = round_away(u[2] * p[0], 30) - round_away(u[0] * p[2], 30);
      q[2] = -round_away(u[1] * p[0], 30);
    end
    for (int k = 0; k < sdft_pkg::NUM_VERTS; k++) begin
      if (k == 0 || k == sdft_pkg::NUM_VERTS - 1) begin
        centre = 1'b0;
        seg = 0;
      end else if (k == sdft_pkg::NUM_VERTS - 2) begin
        centre = 1'b1;
        seg = 0;
      end else begin
        j = k - 1;
        seg = j / 3 + 1;
        centre = (j % 3) == 0;
      end
      rim_angle(seg, c, s);
      for (int a = 0; a < 3; a++) begin
        v = cen[a];
        if (!centre && !degen) begin
          w = round_away(c * p[a] + s * q[a], 34);
          mag = (w < 0) ? longint'(-w) : w;
          off = longint'((r * mag + (64'd1 << 25)) >> 26);
          if (w < 0) off = -off;
          v = cen[a] + off;
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          if (v < -64'sd2147483648) v = -64'sd2147483648;
        end
        if (a == 0) vx.px = v[31:0];
        else if (a == 1) vx.py = v[31:0];
        else vx.pz = v[31:0];
      end
      vx.nx = nx;
      vx.ny = ny;
      vx.nz = nz;
      vx.num = k[4:0];
      vx.last = (k == sdft_pkg::NUM_VERTS - 1);
      vx.degen = degen;
      fan_q = {fan_q, vx};
    end
  endfunction

  always @(posedge clk_i) begin
    vertex_t got, want;
    if (rst_ni && vertex_valid_o) begin
      got = '{pos_x_o, pos_y_o, pos_z_o, out_normal_x_o, out_normal_y_o, out_normal_z_o,
              vertex_number_o, last_vertex_o, degenerate_o};
      if (fan_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex %h", got);
      end else begin
        want = fan_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("vertex mismatch: expected pos %h %h %h nrm %h %h %h num %0d last %b deg %b,"
                     , want.px, want.py, want.pz, want.nx, want.ny, want.nz, want.num,
                     want.last, want.degen,
                     " got pos %h %h %h nrm %h %h %h num %0d last %b deg %b",
                     got.px, got.py, got.pz, got.nx, got.ny, got.nz, got.num,
                     got.last, got.degen);
        end
      end
    end
  end

  // Called at a rising edge; start stays high unless idled, so requests can go back to back.
  task automatic send_disk(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz, logic [31:0] rad,
                           logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
    start_i <= 1'b1;
    center_x_i <= cx;
    center_y_i <= cy;
    center_z_i <= cz;
    disk_radius_i <= rad;
    normal_x_i <= nx;
    normal_y_i <= ny;
    normal_z_i <= nz;
    do @(posedge clk_i); while (busy_o);
    predict_fan(cx, cy, cz, rad, nx, ny, nz);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (fan_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scale(logic [15:0] val);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    radius_scale = val;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_normal();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h4000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed_disks();
    send_disk(0, 0, 0, 32'h0001_0000, 16'h4000, 16'h0000, 16'h0000);
    send_disk(0, 0, 0, 32'h0001_0000, 16'h0000, 16'h0000, 16'h4000);
    send_disk(32'h0010_0000, 32'hFFF0_0000, 32'h1234_5678, 32'h0002_8000, 16'h2D41, 16'h1000,
              16'hD2BF);
    send_disk(32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h0001_0000, 16'h0000, 16'h4000,
              16'h0000);
    send_disk(32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'hFFFF_FFFF, 16'h0000, 16'h0000,
              16'h0000);
    send_disk(32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'hFFFF_FFFF, 16'h0000, 16'h8000,
              16'h0000);
    send_disk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF,
              16'h7FFF);
    send_disk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 16'h8000, 16'h8000,
              16'h8000);
    send_disk(32'h7FFF_0000, 32'h8000_FFFF, 0, 32'h4000_0000, 16'h8000, 16'h0000, 16'h7FFF);
    send_disk(0, 0, 0, 0, 16'h1234, 16'h5678, 16'h9ABC);
    send_disk(32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 16'h0001, 16'hFFFF,
              16'h0001);
    send_disk(0, 0, 0, 32'h0100_0000, 16'hFFFF, 16'h8000, 16'h0000);
    send_disk(0, 0, 0, 32'h0100_0000, 16'h0000, 16'h7FFF, 16'h0001);
    send_disk(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA,
              16'h3333);
  endtask

  task automatic test_scale_extremes();
    write_scale(16'h0000);
    send_disk(32'h0001_0000, 0, 0, 32'hFFFF_FFFF, 16'h4000, 16'h4000, 16'h4000);
    send_disk(0, 32'h8000_0000, 0, 32'h1234_5678, 16'h8000, 16'h0000, 16'h8000);
    write_scale(16'hFFFF);
    send_disk(0, 0, 0, 32'hFFFF_FFFF, 16'h4000, 16'h1000, 16'hC000);
    send_disk(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'h8000);
    send_disk(0, 0, 0, 32'h0000_0003, 16'h0001, 16'h0000, 16'h0000);
    write_scale(16'h0001);
    send_disk(0, 0, 0, 32'hFFFF_FFFF, 16'h2000, 16'h2000, 16'h2000);
  endtask

  task automatic test_random_disks(int count, int pct);
    logic [31:0] cx, cy, cz, rad;
    logic [15:0] nx, ny, nz;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      cx = $urandom;
      cy = $urandom;
      cz = $urandom;
      if ($urandom_range(3) == 0) begin
        cx = {cx[31], {10{~cx[31]}}, cx[20:0]};
      end
      case ($urandom_range(3))
        0: rad = $urandom;
        1: rad = $urandom_range(0, 32'h00FF_FFFF);
        2: rad = $urandom_range(0, 32'h000F_FFFF);
        default: rad = {4'($urandom_range(0, 15)), 28'h0}
                       | 32'($urandom_range(0, 32'h0FFF_FFFF));
      endcase
      nx = pick_normal();
      ny = pick_normal();
      nz = pick_normal();
      if ($urandom_range(9) == 0) begin
        nx = '0;
        nz = '0;
      end
      send_disk(cx, cy, cz, rad, nx, ny, nz);
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_disks();
    test_scale_extremes();
    write_scale(16'h1000);
    test_random_disks(110, 0);
    write_scale(16'($urandom));
    test_random_disks(110, 61);
    write_scale(16'($urandom_range(16'h0800, 16'h3000)));
    test_random_disks(110, 0);
    write_scale(16'($urandom));
    test_random_disks(115, 18);
    wait_drained();
    if (mismatches == 0 && fan_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
